FILE: hdl/bvram_pkg.sv
`default_nettype none

package bvram_pkg;

	localparam int unsigned ADDR_W = 13;
	localparam logic [8:0] ROW_BASE = 9'd256;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_BANK  = 2'd2,
		KIND_PIXEL = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  address;
		logic [7:0]         data;
		logic [7:0]         pixel_x;
		logic [7:0]         pixel_line;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] pixel_color;
		logic [8:0] screen_row;
	} res_t;

	typedef struct packed {
		logic load;
		logic access;
		logic finish;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic clear_done;
	} sts_t;

endpackage

`default_nettype wire

FILE: hdl/bvram_datapath.sv
`default_nettype none

module bvram_datapath #(
	parameter int unsigned PLANE_BYTES = 8192
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bvram_pkg::ctl_t  ctl,
	output bvram_pkg::sts_t       sts,
	input  wire bvram_pkg::req_t  request,
	output bvram_pkg::res_t       response
);
	import bvram_pkg::*;

	localparam int unsigned AW = $clog2(PLANE_BYTES);
	localparam int unsigned RW = 22;

	logic [31:0]   mem [PLANE_BYTES];
	req_t          req_q;
	logic [7:0]    bank_q;
	logic [AW-1:0] clr_q;
	logic [31:0]   rd_s1;
	res_t          res_q;

	logic [ADDR_W-1:0] raw_off;
	logic [RW-1:0]     rem;
	logic [AW-1:0]     off;
	logic [31:0]       wword;
	logic [2:0]        bit_sel;
	res_t              res_d;

	// offset wrap: quotient stays below 32 since the plane holds at least 256 bytes
	always_comb begin
		raw_off = (req_q.kind == KIND_PIXEL) ? {req_q.pixel_x[7:3], req_q.pixel_line}
			: req_q.address;
		rem = {{(RW-ADDR_W){1'b0}}, raw_off};
		for (int k = 4; k >= 0; k--) begin
			if (rem >= (RW'(PLANE_BYTES) << k)) begin
				rem = rem - (RW'(PLANE_BYTES) << k);
			end
		end
		off = rem[AW-1:0];
	end

	always_comb begin
		wword[7:0]   = (bank_q == 8'd0) ? req_q.data : 8'd0;
		wword[15:8]  = bank_q[1] ? req_q.data : 8'd0;
		wword[23:16] = bank_q[2] ? req_q.data : 8'd0;
		wword[31:24] = bank_q[3] ? req_q.data : 8'd0;
	end

	assign bit_sel = req_q.pixel_x[2:0];
	assign sts.clear_done = (clr_q == AW'(PLANE_BYTES - 1));

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			mem[clr_q] <= '0;
		end else if (ctl.access && req_q.kind == KIND_WRITE) begin
			mem[off] <= wword;
		end
		if (ctl.access) begin
			rd_s1 <= mem[off];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			clr_q  <= '0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.access && req_q.kind == KIND_BANK) begin
				bank_q <= req_q.data;
			end
		end
	end

	always_comb begin
		res_d = '0;
		case (req_q.kind)
			KIND_READ: begin
				res_d.read_data = rd_s1[7:0] | rd_s1[15:8] | rd_s1[23:16] | rd_s1[31:24];
			end
			KIND_PIXEL: begin
				res_d.pixel_color = {rd_s1[5'd24 + 5'(bit_sel)], rd_s1[5'd16 + 5'(bit_sel)],
					rd_s1[5'd8 + 5'(bit_sel)], rd_s1[5'(bit_sel)]};
				res_d.screen_row = ROW_BASE - {1'b0, req_q.pixel_line};
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= request;
		end
		if (ctl.finish) begin
			res_q <= res_d;
		end
	end

	assign response = res_q;

endmodule

`default_nettype wire

FILE: hdl/bvram_ctrl.sv
`default_nettype none

module bvram_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bvram_pkg::sts_t  sts,
	output bvram_pkg::ctl_t       ctl,
	output logic                  busy,
	output logic                  done
);
	import bvram_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_FORM
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ACCESS;
						busy_q  <= 1'b1;
					end
				end
				ST_ACCESS: begin
					state_q <= ST_FORM;
				end
				ST_FORM: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign ctl.load   = (state_q == ST_IDLE) && start;
	assign ctl.access = (state_q == ST_ACCESS);
	assign ctl.finish = (state_q == ST_FORM);
	assign ctl.clear  = (state_q == ST_CLEAR);
	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: hdl/bitplane_video_ram_with_plane_select.sv
// a word is read in the access state, its result registered in form state, strobed by done
// one word at a time: the single port of the plane memory and the
//   access/form sequence of the controller set this, and busy drops in the cycle done is high
// reset: planes are cleared one offset per cycle from 0 to PLANE_BYTES-1, busy high meanwhile
// results cannot be stalled by the receiver
`default_nettype none

module bitplane_video_ram_with_plane_select #(
	parameter int unsigned PLANE_BYTES = 8192
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bvram_pkg::req_t  request,
	output logic                  done,
	output bvram_pkg::res_t       response
);
	import bvram_pkg::*;

	ctl_t ctl;
	sts_t sts;

	bvram_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	bvram_datapath #(
		.PLANE_BYTES (PLANE_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.request  (request),
		.response (response)
	);

endmodule

`default_nettype wire

FILE: hdl/bvram_checker.sv
`default_nettype none

module bvram_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire bvram_pkg::req_t  request,
	input wire logic             done,
	input wire bvram_pkg::res_t  response
);
	import bvram_pkg::*;

	logic unused_req;
	assign unused_req = ^request;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result not delivered three cycles after accept");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy high while result is shown");

	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (response.read_data == 8'd0
			|| (response.pixel_color == 4'd0 && response.screen_row == 9'd0)))
		else $error("read and pixel fields both nonzero");

endmodule

bind bitplane_video_ram_with_plane_select bvram_checker u_bvram_checker (.*);

`default_nettype wire

FILE: dv/plane_access_checker.sv
module plane_access_checker
	import bvram_pkg::*;
#(
	parameter int unsigned PLANE_BYTES = 8192
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t request,
	input  wire logic done,
	input  wire res_t response,
	output int        mismatches,
	output int        in_flight
);

	logic [7:0] planes [4][PLANE_BYTES];
	logic [7:0] bank;
	res_t       awaited_words [$];
	int         mismatch_total;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_total++;
	endtask

	// updates the plane copy and bank for one accepted word, returns its result
	function automatic res_t plane_access_result(input req_t w);
		res_t        r;
		int unsigned off;
		int unsigned bit_sel;
		r = '0;
		case (w.kind)
			KIND_READ: begin
				off = int'(w.address) % PLANE_BYTES;
				for (int p = 0; p < 4; p++)
					r.read_data |= planes[p][off];
			end
			KIND_WRITE: begin
				off = int'(w.address) % PLANE_BYTES;
				planes[0][off] = (bank == 8'h00) ? w.data : 8'h00;
				for (int p = 1; p < 4; p++)
					planes[p][off] = bank[p] ? w.data : 8'h00;
			end
			KIND_BANK: begin
				bank = w.data;
			end
			KIND_PIXEL: begin
				off = (int'(w.pixel_x >> 3) * 256 + int'(w.pixel_line)) % PLANE_BYTES;
				bit_sel = int'(w.pixel_x[2:0]);
				for (int p = 0; p < 4; p++)
					r.pixel_color[p] = planes[p][off][bit_sel];
				r.screen_row = ROW_BASE - 9'(w.pixel_line);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int p = 0; p < 4; p++)
				for (int a = 0; a < PLANE_BYTES; a++)
					planes[p][a] = 8'h00;
			bank = 8'h00;
			awaited_words.delete();
			mismatch_total = 0;
			mismatches <= 0;
			in_flight <= 0;
		end else begin
			if (done) begin
				if (awaited_words.size() == 0) begin
					report_mismatch($sformatf("result %p with no word pending", response));
				end else begin
					want = awaited_words.pop_front();
					if (response.read_data !== want.read_data)
						report_mismatch($sformatf("read_data got %h want %h",
							response.read_data, want.read_data));
					if (response.pixel_color !== want.pixel_color)
						report_mismatch($sformatf("pixel_color got %h want %h",
							response.pixel_color, want.pixel_color));
					if (response.screen_row !== want.screen_row)
						report_mismatch($sformatf("screen_row got %h want %h",
							response.screen_row, want.screen_row));
				end
			end
			if (start && !busy)
				awaited_words.push_back(plane_access_result(request));
			mismatches <= mismatch_total;
			in_flight <= awaited_words.size();
		end
	end

endmodule

FILE: dv/bitplane_video_ram_with_plane_select_test.sv
module bitplane_video_ram_with_plane_select_test;
	import bvram_pkg::*;

	localparam int unsigned PLANE_BYTES = 8192;
	localparam int RANDOM_WORDS = 1130;
	localparam int HOT_COUNT = 12;
	// reset clearing walks every plane offset with nothing accepted
	localparam int IDLE_LIMIT = 4 * PLANE_BYTES + 1000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	req_t  request = '0;
	logic  done;
	res_t  response;
	int    mismatches;
	int    in_flight;
	int    idle_cycles = 0;
	int    burst_left = 0;
	logic [ADDR_W-1:0] hot_addr [HOT_COUNT];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	bitplane_video_ram_with_plane_select #(
		.PLANE_BYTES(PLANE_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response)
	);

	plane_access_checker #(
		.PLANE_BYTES(PLANE_BYTES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t make_word(input kind_t k, input logic [ADDR_W-1:0] a,
		input logic [7:0] d, input logic [7:0] x, input logic [7:0] l);
		req_t w;
		w.kind = k;
		w.address = a;
		w.data = d;
		w.pixel_x = x;
		w.pixel_line = l;
		return w;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		if ($urandom_range(0, 99) < 80)
			return hot_addr[$urandom_range(0, HOT_COUNT - 1)];
		return ADDR_W'($urandom);
	endfunction

	function automatic req_t random_word();
		req_t             w;
		logic [ADDR_W-1:0] a;
		int unsigned      r;
		w = req_t'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 10) begin
			w.kind = KIND_BANK;
			case ($urandom_range(0, 4))
				0: w.data = 8'h00;
				1: w.data = 8'h01;
				2: w.data = 8'h0e;
				3: w.data = {4'($urandom), 3'($urandom), 1'b0};
				default: w.data = 8'($urandom);
			endcase
		end else if (r < 45) begin
			w.kind = KIND_WRITE;
			w.address = pick_addr();
		end else if (r < 70) begin
			w.kind = KIND_READ;
			w.address = pick_addr();
		end else begin
			w.kind = KIND_PIXEL;
			if ($urandom_range(0, 99) < 80) begin
				// aim the fetch at an offset that writes are hitting
				a = pick_addr();
				w.pixel_x = {a[12:8], 3'($urandom)};
				w.pixel_line = a[7:0];
			end
		end
		return w;
	endfunction

	// holds start high across a burst, drops it for a random gap, sometimes none, between bursts
	task automatic issue(input req_t w);
		int gap;
		request <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
	endtask

	initial begin
		for (int i = 0; i < HOT_COUNT; i++)
			hot_addr[i] = ADDR_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// cleared store, then plane 0 only
		issue(make_word(KIND_READ, 13'h0000, 8'h00, 8'h00, 8'h00));
		issue(make_word(KIND_PIXEL, 13'h0000, 8'h00, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h0000, 8'hff, 8'h00, 8'h00));
		issue(make_word(KIND_READ, 13'h0000, 8'h00, 8'hff, 8'hff));
		issue(make_word(KIND_PIXEL, 13'h1fff, 8'hff, 8'h07, 8'h00));
		// planes 1 to 3 at the top offset
		issue(make_word(KIND_BANK, 13'h0000, 8'h0e, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h1fff, 8'ha5, 8'h00, 8'h00));
		issue(make_word(KIND_READ, 13'h1fff, 8'h00, 8'h00, 8'h00));
		issue(make_word(KIND_PIXEL, 13'h0000, 8'h00, 8'hff, 8'hff));
		issue(make_word(KIND_PIXEL, 13'h0000, 8'h00, 8'hfe, 8'hff));
		// bank one clears every plane
		issue(make_word(KIND_BANK, 13'h0000, 8'h01, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h1fff, 8'hff, 8'h00, 8'h00));
		issue(make_word(KIND_READ, 13'h1fff, 8'h00, 8'h00, 8'h00));
		// upper bank bits select nothing
		issue(make_word(KIND_BANK, 13'h0000, 8'hf0, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h1234, 8'h5a, 8'h00, 8'h00));
		issue(make_word(KIND_READ, 13'h1234, 8'h00, 8'h00, 8'h00));
		issue(make_word(KIND_BANK, 13'h0000, 8'hff, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h0aaa, 8'hff, 8'h00, 8'h00));
		issue(make_word(KIND_READ, 13'h0aaa, 8'h00, 8'h00, 8'h00));
		issue(make_word(KIND_PIXEL, 13'h0000, 8'h00, 8'h53, 8'haa));
		issue(make_word(KIND_BANK, 13'h0000, 8'h02, 8'h00, 8'h00));
		issue(make_word(KIND_WRITE, 13'h1555, 8'h81, 8'h00, 8'h00));
		issue(make_word(KIND_PIXEL, 13'h0000, 8'h00, 8'ha8, 8'h55));
		issue(make_word(KIND_BANK, 13'h0000, 8'h00, 8'h00, 8'h00));

		for (int i = 0; i < RANDOM_WORDS; i++)
			issue(random_word());
		start <= 1'b0;

		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/bvram_pkg.sv
hdl/bvram_datapath.sv
hdl/bvram_ctrl.sv
hdl/bitplane_video_ram_with_plane_select.sv
hdl/bvram_checker.sv
dv/plane_access_checker.sv
dv/bitplane_video_ram_with_plane_select_test.sv
